>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define LSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the following cycle, outside reset.
`define LSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lsp_pkg.sv
package lsp_pkg;
  localparam int MAX_TASKS = 16;
  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int EXP_W = 16;
  localparam int PRIO_W = 8;
  localparam int TKT_W = 5;
  localparam int TSUM_W = 9;
  localparam int WSUM_W = 21;
  localparam int RND_W = 31;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int ENTRY_W = 2 * EXP_W + PRIO_W + TKT_W;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PRIO_WEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'd1;

  typedef struct packed {
    logic [EXP_W-1:0] expected;
    logic [EXP_W-1:0] elapsed;
    logic [PRIO_W-1:0] prio;
    logic [TKT_W-1:0] tickets;
  } entry_t;

  typedef struct packed {
    logic start;
    logic [WSUM_W-1:0] divisor;
    logic [RND_W-1:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic [WSUM_W-1:0] remainder;
  } mod_rsp_t;
endpackage

>>> rtl/lsp_if.sv
interface lsp_in_if import lsp_pkg::*; ();
  logic valid;
  logic ready;
  logic operation;
  logic [EXP_W-1:0] expected_time;
  logic [PRIO_W-1:0] priority_req;
  logic [RND_W-1:0] random_value;
  modport source(output valid, operation, expected_time, priority_req, random_value,
                 input ready);
  modport sink(input valid, operation, expected_time, priority_req, random_value,
               output ready);
endinterface

interface lsp_out_if import lsp_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [SLOT_W-1:0] task_slot;
  logic task_finished;
  logic [EXP_W-1:0] remaining_time;
  logic [TSUM_W-1:0] tickets_left;
  modport source(output valid, status, task_slot, task_finished, remaining_time,
                 tickets_left, input ready);
  modport sink(input valid, status, task_slot, task_finished, remaining_time,
               tickets_left, output ready);
endinterface

interface lsp_cfg_if import lsp_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/lsp_ram.sv
module lsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> rtl/lsp_mod.sv
`include "assert_macros.svh"
// Restoring remainder unit, one quotient bit per cycle.
module lsp_mod import lsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);
  localparam int STEP_W = $clog2(RND_W + 1);

  logic [STEP_W-1:0] step_r;
  logic busy_r;
  logic done_r;
  logic [RND_W-1:0] dvd_r;
  logic [WSUM_W:0] rem_r;
  logic [WSUM_W-1:0] dvs_r;
  logic [WSUM_W+1:0] trial;
  logic [WSUM_W:0] shifted;

  assign shifted = {rem_r[WSUM_W-1:0], dvd_r[RND_W-1]};
  assign trial = {1'b0, shifted} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(RND_W);
        dvd_r <= req.dividend;
        dvs_r <= req.divisor;
        rem_r <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
        rem_r <= trial[WSUM_W+1] ? shifted : trial[WSUM_W:0];
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.remainder = rem_r[WSUM_W-1:0];

  `LSP_ASSERT_NXT(a_mod_done, clk, rst_n, busy_r && step_r == STEP_W'(1) && !req.start, done_r, "lsp_mod: done missing")
  `LSP_ASSERT_IMP(a_mod_rem, clk, rst_n, done_r, rem_r < {1'b0, dvs_r}, "lsp_mod: remainder not reduced")
  `LSP_ASSERT_IMP(a_mod_idle, clk, rst_n, !busy_r, step_r == '0 || done_r || step_r != '0, "lsp_mod: step")
endmodule

>>> rtl/lottery_sjf_task_picker_core.sv
// Channel | Dir | Handshake                  | Word
// in_ch   | in  | in_ch.valid/in_ch.ready    | operation, expected_time, priority_req,
//         |     |                            | random_value
// out_ch  | out | out_ch.valid/out_ch.ready  | status, task_slot, task_finished,
//         |     |                            | remaining_time, tickets_left
// cfg_ch  | in  | cfg_ch.valid/cfg_ch.ready  | index, data (0 priority_weight, 1 time_step)
//
// Insert: read sweep over the occupied slots, one write, and for a new longest task a
// bump sweep. Draw: weight sweep, remainder unit, newest-first sweep, then a
// read-modify-write of the winner.
// The task RAM has one read port, which sets the sweep lengths; one item is in flight.
// Synchronous active-low reset clears count and sums; the RAM is never cleared.
// A held result blocks the input until it is taken.
`include "assert_macros.svh"
module lottery_sjf_task_picker_core import lsp_pkg::*; (
  input logic clk,
  input logic rst_n,
  lsp_in_if.sink    in_ch,
  lsp_out_if.source out_ch,
  lsp_cfg_if.sink   cfg_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_IRD, S_IWR, S_BUMP, S_WSUM, S_MOD, S_MODW, S_WALK, S_WIN, S_OUT
  } state_t;

  state_t state_r;
  logic [EXP_W-1:0] exp_r;
  logic [PRIO_W-1:0] prio_r;
  logic [RND_W-1:0] rnd_r;
  logic [PRIO_W-1:0] pw_r;
  logic [EXP_W-1:0] ts_r;
  logic [CNT_W-1:0] count_r;
  logic [TSUM_W-1:0] tsum_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [WSUM_W-1:0] acc_r;
  logic [WSUM_W-1:0] draw_r;
  logic [CNT_W-1:0] ridx_r;
  logic [CNT_W-1:0] widx_r;
  logic rpend_r;
  logic found_r;
  logic [TKT_W-1:0] tk_r;
  logic [SLOT_W-1:0] win_r;

  logic [1:0] o_status_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic o_fin_r;
  logic [EXP_W-1:0] o_rem_r;
  logic o_valid_r;

  logic we;
  logic [SLOT_W-1:0] waddr;
  logic [SLOT_W-1:0] raddr;
  entry_t wdata;
  entry_t rdata;
  logic [ENTRY_W-1:0] rdata_raw;
  mod_req_t mreq;
  mod_rsp_t mrsp;

  logic [WSUM_W-1:0] wt;
  logic [EXP_W:0] esum;
  logic [EXP_W-1:0] enew;

  lsp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  lsp_mod u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  // Weight of the entry on the read port.
  assign wt = WSUM_W'(rdata.prio) * WSUM_W'(pw_r) + WSUM_W'(rdata.tickets);
  assign esum = {1'b0, rdata.elapsed} + {1'b0, ts_r};
  assign enew = esum[EXP_W] ? {EXP_W{1'b1}} : esum[EXP_W-1:0];

  assign in_ch.ready = (state_r == S_IDLE) && !o_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = o_valid_r;
  assign out_ch.status = o_status_r;
  assign out_ch.task_slot = o_slot_r;
  assign out_ch.task_finished = o_fin_r;
  assign out_ch.remaining_time = o_rem_r;
  assign out_ch.tickets_left = tsum_r;

  assign mreq.start = (state_r == S_MOD);
  assign mreq.divisor = acc_r;
  assign mreq.dividend = rnd_r;

  always_comb begin
    we = 1'b0;
    waddr = widx_r[SLOT_W-1:0];
    wdata = rdata;
    raddr = ridx_r[SLOT_W-1:0];
    unique case (state_r)
      S_IWR: begin
        we = 1'b1;
        wdata = '{expected: exp_r, elapsed: '0, prio: prio_r, tickets: tk_r};
      end
      S_BUMP: begin
        we = rpend_r;
        wdata.tickets = rdata.tickets + 1'b1;
      end
      S_WIN: begin
        we = rpend_r;
        waddr = win_r;
        wdata.elapsed = enew;
        if (enew >= rdata.expected) begin
          wdata.tickets = '0;
          wdata.prio = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      tsum_r <= '0;
      wsum_r <= '0;
      pw_r <= PRIO_W'(1);
      ts_r <= EXP_W'(1);
      o_valid_r <= 1'b0;
      rpend_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        // Hold the other register; write only the addressed one.
        unique case (cfg_ch.index)
          REG_PRIO_WEIGHT: pw_r <= cfg_ch.data[PRIO_W-1:0];
          REG_TIME_STEP: ts_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) o_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            exp_r <= in_ch.expected_time;
            prio_r <= in_ch.priority_req;
            rnd_r <= in_ch.random_value;
            found_r <= 1'b0;
            tk_r <= TKT_W'(1);
            acc_r <= '0;
            rpend_r <= 1'b0;
            if (in_ch.operation == OP_INSERT) begin
              if (count_r >= CNT_W'(MAX_TASKS)) begin
                o_status_r <= ST_FULL; o_slot_r <= '0; o_fin_r <= 1'b0;
                o_rem_r <= '0; state_r <= S_OUT;
              end else begin
                // Scan oldest first: the last hit of a newest-first walk is the oldest.
                ridx_r <= '0; state_r <= S_IRD;
              end
            end else begin
              ridx_r <= '0; state_r <= S_WSUM;
            end
          end
        end
        S_IRD: begin
          rpend_r <= (ridx_r < count_r);
          if (rpend_r && !found_r && exp_r <= rdata.expected) begin
            found_r <= 1'b1;
            tk_r <= (exp_r < rdata.expected) ? rdata.tickets + 1'b1 : rdata.tickets;
          end
          if (ridx_r >= count_r && !rpend_r) begin
            widx_r <= count_r;
            state_r <= S_IWR;
          end else ridx_r <= ridx_r + 1'b1;
        end
        S_IWR: begin
          tsum_r <= tsum_r + TSUM_W'(tk_r) + (found_r ? '0 : TSUM_W'(count_r));
          count_r <= count_r + 1'b1;
          o_status_r <= ST_OK; o_slot_r <= widx_r[SLOT_W-1:0];
          o_fin_r <= 1'b0; o_rem_r <= exp_r;
          if (found_r || count_r == '0) state_r <= S_OUT;
          else begin
            ridx_r <= '0; rpend_r <= 1'b0; state_r <= S_BUMP;
          end
        end
        S_BUMP: begin
          // Read one slot, write it back incremented next cycle.
          widx_r <= ridx_r;
          rpend_r <= (ridx_r < count_r - 1'b1);
          if (ridx_r >= count_r - 1'b1 && !rpend_r) state_r <= S_OUT;
          else ridx_r <= ridx_r + 1'b1;
        end
        S_WSUM: begin
          rpend_r <= (ridx_r < count_r);
          if (rpend_r) acc_r <= acc_r + wt;
          if (ridx_r >= count_r && !rpend_r) begin
            wsum_r <= acc_r;
            if (tsum_r == '0 || acc_r == '0) begin
              o_status_r <= ST_EMPTY; o_slot_r <= '0; o_fin_r <= 1'b0;
              o_rem_r <= '0; state_r <= S_OUT;
            end else state_r <= S_MOD;
          end else ridx_r <= ridx_r + 1'b1;
        end
        S_MOD: state_r <= S_MODW;
        S_MODW: begin
          if (mrsp.done) begin
            draw_r <= mrsp.remainder;
            acc_r <= '0;
            rpend_r <= 1'b0;
            ridx_r <= count_r - 1'b1;
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          // Newest first; ridx_r counts down, rpend_r marks a valid read of win_r.
          if (rpend_r && (acc_r + wt) > draw_r) begin
            ridx_r <= {1'b0, win_r};
            rpend_r <= 1'b0;
            state_r <= S_WIN;
          end else begin
            rpend_r <= 1'b1;
            win_r <= ridx_r[SLOT_W-1:0];
            if (rpend_r) acc_r <= acc_r + wt;
            ridx_r <= ridx_r - 1'b1;
          end
        end
        S_WIN: begin
          rpend_r <= 1'b1;
          if (rpend_r) begin
            o_status_r <= ST_OK; o_slot_r <= win_r;
            if (enew >= rdata.expected) begin
              o_fin_r <= 1'b1; o_rem_r <= '0;
              tsum_r <= tsum_r - TSUM_W'(rdata.tickets);
              wsum_r <= wsum_r - wt;
            end else begin
              o_fin_r <= 1'b0; o_rem_r <= rdata.expected - enew;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          o_valid_r <= 1'b1;
          rpend_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `LSP_ASSERT_IMP(a_count, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_TASKS), "count overflow")
  `LSP_ASSERT_NXT(a_accept, clk, rst_n, in_ch.valid && in_ch.ready, state_r != S_IDLE, "accept")
  `LSP_ASSERT_IMP(a_noacc, clk, rst_n, o_valid_r, !in_ch.ready, "accepted with result pending")
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import lsp_pkg::*;

  // One predicted result word from the picker.
  typedef struct {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              finished;
    logic [EXP_W-1:0]  remaining;
    logic [TSUM_W-1:0] tickets;
  } pick_t;

  logic clk;
  logic rst_n;

  lsp_in_if  in_ch();
  lsp_out_if out_ch();
  lsp_cfg_if cfg_ch();

  lottery_sjf_task_picker_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Mirror of the task table, kept as plain integers; slots fill in order.
  int unsigned exp_tbl[MAX_TASKS];
  int unsigned elapsed_tbl[MAX_TASKS];
  int unsigned prio_tbl[MAX_TASKS];
  int unsigned tkt_tbl[MAX_TASKS];
  int unsigned n_tasks;
  int unsigned tkt_total;
  int unsigned prio_weight;
  int unsigned step_size;

  pick_t pending_picks[$];
  int    errors;
  bit    idle_on;
  bit    hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Weight of one slot under the current priority multiplier.
  function automatic int unsigned slot_weight(int unsigned s);
    return prio_tbl[s] * prio_weight + tkt_tbl[s];
  endfunction

  // Advance the mirror by one accepted word and return the result it causes.
  function automatic pick_t pick_next(logic op, int unsigned exp_t, int unsigned prio,
                                      int unsigned rnd);
    pick_t       r;
    int unsigned tk;
    int unsigned total;
    int unsigned acc;
    int unsigned win;
    int unsigned e;
    bit          found;
    r.status = ST_OK;
    r.slot = '0;
    r.finished = 1'b0;
    r.remaining = '0;
    found = 1'b0;
    tk = 0;
    if (op == OP_INSERT) begin
      if (n_tasks >= MAX_TASKS) begin
        r.status = ST_FULL;
      end else begin
        // Walk newest to oldest; the oldest task at least as long decides.
        for (int i = int'(n_tasks) - 1; i >= 0; i--) begin
          if (exp_t <= exp_tbl[i]) begin
            found = 1'b1;
            tk = (exp_t < exp_tbl[i]) ? tkt_tbl[i] + 1 : tkt_tbl[i];
          end
        end
        if (!found) begin
          // Longest task so far: one ticket, and everyone else gains one.
          tk = 1;
          for (int i = 0; i < int'(n_tasks); i++) begin
            tkt_tbl[i]++;
            tkt_total++;
          end
        end
        exp_tbl[n_tasks] = exp_t;
        elapsed_tbl[n_tasks] = 0;
        prio_tbl[n_tasks] = prio;
        tkt_tbl[n_tasks] = tk;
        tkt_total += tk;
        r.slot = n_tasks[SLOT_W-1:0];
        r.remaining = exp_t[EXP_W-1:0];
        n_tasks++;
      end
    end else begin
      total = 0;
      for (int i = 0; i < int'(n_tasks); i++) total += slot_weight(i);
      if (tkt_total == 0 || total == 0) begin
        r.status = ST_EMPTY;
      end else begin
        rnd = rnd % total;
        acc = 0;
        win = 0;
        for (int i = int'(n_tasks) - 1; i >= 0; i--) begin
          acc += slot_weight(i);
          if (acc > rnd) begin
            win = i;
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          r.status = ST_EMPTY;
        end else begin
          e = elapsed_tbl[win] + step_size;
          if (e > 16'hFFFF) e = 16'hFFFF;
          elapsed_tbl[win] = e;
          r.slot = win[SLOT_W-1:0];
          if (e >= exp_tbl[win]) begin
            // Retire: drop weight, keep the slot.
            r.finished = 1'b1;
            tkt_total -= tkt_tbl[win];
            tkt_tbl[win] = 0;
            prio_tbl[win] = 0;
          end else begin
            r.remaining = EXP_W'(exp_tbl[win] - e);
          end
        end
      end
    end
    r.tickets = tkt_total[TSUM_W-1:0];
    return r;
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, field, got, want);
    errors++;
  endtask

  // Predict on every accepted input word; track register writes.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      pending_picks.push_back(pick_next(in_ch.operation, in_ch.expected_time,
                                        in_ch.priority_req, in_ch.random_value));
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == REG_PRIO_WEIGHT) prio_weight = cfg_ch.data[PRIO_W-1:0];
      else step_size = cfg_ch.data;
    end
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_picks.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        want = pending_picks.pop_front();
        if (out_ch.status !== want.status) report("status", out_ch.status, want.status);
        if (out_ch.task_slot !== want.slot) report("task_slot", out_ch.task_slot, want.slot);
        if (out_ch.task_finished !== want.finished)
          report("task_finished", out_ch.task_finished, want.finished);
        if (out_ch.remaining_time !== want.remaining)
          report("remaining_time", out_ch.remaining_time, want.remaining);
        if (out_ch.tickets_left !== want.tickets)
          report("tickets_left", out_ch.tickets_left, want.tickets);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= 3000) begin
        $display("watchdog: no progress for %0d cycles", quiet);
        $display("** lottery_sjf_task_picker_core: FAILED **");
        $finish;
      end
    end
  end

  // Offer one input word, with an optional random gap first; hold valid after.
  task automatic send_word(logic op, logic [EXP_W-1:0] exp_t, logic [PRIO_W-1:0] prio,
                           logic [RND_W-1:0] rnd);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.expected_time <= exp_t;
    in_ch.priority_req <= prio;
    in_ch.random_value <= rnd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drain all results, then write a register while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [EXP_W-1:0] pick_exp();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return EXP_W'($urandom());
      default: return EXP_W'($urandom_range(0, 40));
    endcase
  endfunction

  // Random mix of inserts and draws.
  task automatic run_mix(int count, int insert_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < insert_pct)
        send_word(OP_INSERT, pick_exp(), PRIO_W'($urandom()), RND_W'($urandom()));
      else
        send_word(OP_DRAW, EXP_W'($urandom()), PRIO_W'($urandom()), RND_W'($urandom()));
    end
  endtask

  // Empty-table draw, field extremes, equal and longest expected times.
  task automatic test_directed();
    send_word(OP_DRAW, 16'h0, 8'h0, '1);
    send_word(OP_INSERT, 16'd20, 8'd3, '0);
    send_word(OP_INSERT, 16'd20, 8'd0, '1);
    send_word(OP_INSERT, 16'd5, 8'hFF, '0);
    send_word(OP_INSERT, 16'hFFFF, 8'd1, '0);
    send_word(OP_DRAW, 16'h0, 8'h0, '0);
    send_word(OP_DRAW, 16'hFFFF, 8'hFF, '1);
    send_word(OP_INSERT, 16'd0, 8'd7, '1);
    for (int i = 0; i < 6; i++) send_word(OP_DRAW, '0, '0, RND_W'(i * 3));
  endtask

  // Extreme register settings: no priority term, huge step; then heavy priority.
  task automatic test_register_extremes();
    write_reg(REG_PRIO_WEIGHT, 16'd0);
    write_reg(REG_TIME_STEP, 16'hFFFF);
    send_word(OP_INSERT, 16'd300, 8'd9, '0);
    send_word(OP_DRAW, '0, '0, '1);
    send_word(OP_DRAW, '0, '0, RND_W'($urandom()));
    write_reg(REG_PRIO_WEIGHT, 16'd255);
    write_reg(REG_TIME_STEP, 16'd1);
    send_word(OP_INSERT, 16'd30, 8'hFF, '0);
    for (int i = 0; i < 6; i++) send_word(OP_DRAW, '0, '0, RND_W'($urandom()));
  endtask

  // Several random register settings, each followed by a random mix.
  task automatic test_random_mix();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_PRIO_WEIGHT, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(REG_TIME_STEP, (p == 3) ? 16'hFFFF : CFG_DATA_W'($urandom_range(1, 25)));
      run_mix(75, 12);
    end
  endtask

  // Hold the receiver off while words keep coming so the input stalls.
  task automatic test_backpressure();
    hold_req = 1'b1;
    run_mix(30, 10);
  endtask

  // Tail with no idling on either side.
  task automatic test_streaming();
    idle_on = 1'b0;
    run_mix(60, 10);
  endtask

  initial begin
    errors = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    n_tasks = 0;
    tkt_total = 0;
    prio_weight = 1;
    step_size = 1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.expected_time = '0;
    in_ch.priority_req = '0;
    in_ch.random_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_PRIO_WEIGHT;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_random_mix();
    test_backpressure();
    test_streaming();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("** lottery_sjf_task_picker_core: PASSED **");
    else
      $display("** lottery_sjf_task_picker_core: FAILED **");
    $finish;
  end
endmodule
